FILE: rtl/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg
// Shared constants, action codes and types for the record substring filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int CNT_W       = 16;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_TEXT  = 2'd2,
        ACT_END   = 2'd3
    } rsf_action_t;

    typedef logic [7:0] rsf_byte_t;
    typedef rsf_byte_t [MAX_PATTERN-1:0] rsf_bytes_t;

    typedef struct packed {
        logic      load;
        logic      clear;
        logic      text;
        logic      close;
        rsf_byte_t data;
    } rsf_op_t;

endpackage

FILE: rtl/record_substring_filter.sv
// ----------------------------------------------------------------------------
// record_substring_filter
// Top level: input register, action decode, pattern, window and tally.
// ----------------------------------------------------------------------------
// One word is taken per cycle. Each word sits in the input register and is
// processed there: the text window is compared with the pattern across all
// lanes at once. An end-of-record word loads the result register when it is
// processed, so its result appears in the cycle after; the input side stalls
// only when an end-of-record word waits behind a result that is itself
// stalled.
module record_substring_filter
    import rsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             record_matched,
    output logic [CNT_W-1:0] record_index,
    output logic [CNT_W-1:0] match_count,
    output logic             first_match_res
);

    logic             in_valid_reg;
    rsf_action_t      act_reg;
    rsf_byte_t        data_reg;
    logic             go;
    rsf_op_t          op;
    rsf_bytes_t       pattern;
    logic [LEN_W-1:0] pattern_len;
    logic             hit;

    assign go       = in_valid_reg && ((act_reg != ACT_END) || !out_valid || !out_stall);
    assign in_stall = in_valid_reg && !go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            act_reg  <= rsf_action_t'(action);
            data_reg <= data_byte;
        end
    end

    always_comb
    begin
        op      = '0;
        op.data = data_reg;
        unique case (act_reg)
            ACT_LOAD:  op.load  = go;
            ACT_CLEAR: op.clear = go;
            ACT_TEXT:  op.text  = go;
            ACT_END:   op.close = go;
            default:   op.load  = 1'b0;
        endcase
    end

    rsf_pattern u_pattern (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .pattern     (pattern),
        .pattern_len (pattern_len)
    );

    rsf_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .pattern     (pattern),
        .pattern_len (pattern_len),
        .hit         (hit)
    );

    rsf_tally u_tally (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .hit             (hit),
        .pattern_empty   (pattern_len == '0),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .record_matched  (record_matched),
        .record_index    (record_index),
        .match_count     (match_count),
        .first_match_res (first_match_res)
    );

endmodule

FILE: rtl/rsf_pattern.sv
// ----------------------------------------------------------------------------
// rsf_pattern
// Pattern store held newest byte first, so lane j lines up with window lane j.
// ----------------------------------------------------------------------------
module rsf_pattern
    import rsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rsf_op_t          op,
    output rsf_bytes_t       pattern,
    output logic [LEN_W-1:0] pattern_len
);

    rsf_bytes_t       pat_reg;
    rsf_bytes_t       pat_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             take;

    assign take = op.load && (len_reg != LEN_MAX);

    always_comb
    begin
        pat_next    = pat_reg;
        pat_next[0] = op.data;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            pat_next[j] = pat_reg[j-1];
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (op.clear)
        begin
            len_next = '0;
        end
        else if (take)
        begin
            len_next = len_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pat_reg <= pat_next;
        end
    end

    assign pattern     = pat_reg;
    assign pattern_len = len_reg;

endmodule

FILE: rtl/rsf_window.sv
// ----------------------------------------------------------------------------
// rsf_window
// Text window and per-record byte count; compares all lanes against the
// pattern in parallel and flags a hit on each text word that completes a match.
// ----------------------------------------------------------------------------
module rsf_window
    import rsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rsf_op_t          op,
    input  rsf_bytes_t       pattern,
    input  logic [LEN_W-1:0] pattern_len,
    output logic             hit
);

    rsf_bytes_t       win_reg;
    rsf_bytes_t       win_next;
    logic [LEN_W-1:0] seen_reg;
    logic [LEN_W-1:0] seen_next;
    logic [LEN_W-1:0] seen_inc;
    logic             lanes_ok;

    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = op.data;
        for (int j = 1; j < MAX_PATTERN; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
    end

    assign seen_inc = (seen_reg == LEN_MAX) ? seen_reg : seen_reg + LEN_W'(1);

    always_comb
    begin
        lanes_ok = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if ((LEN_W'(j) < pattern_len) && (win_next[j] != pattern[j]))
            begin
                lanes_ok = 1'b0;
            end
        end
    end

    assign hit = op.text && lanes_ok && (seen_inc >= pattern_len);

    always_comb
    begin
        seen_next = seen_reg;
        if (op.clear || op.close)
        begin
            seen_next = '0;
        end
        else if (op.text)
        begin
            seen_next = seen_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.text)
        begin
            win_reg <= win_next;
        end
    end

endmodule

FILE: rtl/rsf_tally.sv
// ----------------------------------------------------------------------------
// rsf_tally
// Sticky found flag, record and match counters, and the result register.
// ----------------------------------------------------------------------------
module rsf_tally
    import rsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  rsf_op_t          op,
    input  logic             hit,
    input  logic             pattern_empty,
    input  logic             out_stall,
    output logic             out_valid,
    output logic             record_matched,
    output logic [CNT_W-1:0] record_index,
    output logic [CNT_W-1:0] match_count,
    output logic             first_match_res
);

    logic             found_reg;
    logic             found_next;
    logic [CNT_W-1:0] rec_cnt_reg;
    logic [CNT_W-1:0] rec_cnt_next;
    logic [CNT_W-1:0] match_cnt_reg;
    logic [CNT_W-1:0] match_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic [CNT_W-1:0] index_reg;
    logic [CNT_W-1:0] count_reg;
    logic             first_reg;
    logic             matched;

    assign matched = found_reg || pattern_empty;

    always_comb
    begin
        found_next     = found_reg;
        rec_cnt_next   = rec_cnt_reg;
        match_cnt_next = match_cnt_reg;
        if (op.clear)
        begin
            found_next     = 1'b0;
            rec_cnt_next   = '0;
            match_cnt_next = '0;
        end
        else if (op.close)
        begin
            found_next = 1'b0;
            if (rec_cnt_reg != CNT_MAX)
            begin
                rec_cnt_next = rec_cnt_reg + CNT_W'(1);
            end
            if (matched && (match_cnt_reg != CNT_MAX))
            begin
                match_cnt_next = match_cnt_reg + CNT_W'(1);
            end
        end
        else if (hit)
        begin
            found_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (op.close)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            rec_cnt_reg   <= '0;
            match_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            rec_cnt_reg   <= rec_cnt_next;
            match_cnt_reg <= match_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.close)
        begin
            matched_reg <= matched;
            index_reg   <= rec_cnt_reg;
            count_reg   <= match_cnt_next;
            first_reg   <= matched && (match_cnt_reg == '0);
        end
    end

    assign out_valid       = out_valid_reg;
    assign record_matched  = matched_reg;
    assign record_index    = index_reg;
    assign match_count     = count_reg;
    assign first_match_res = first_reg;

    a_first_is_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && first_reg |-> matched_reg && (count_reg == CNT_W'(1)))
        else $error("first match without a count of one");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && matched_reg |-> (count_reg != '0))
        else $error("matched record with zero match count");

    a_match_le_rec: assert property (@(posedge clk) disable iff (!rst_n)
        match_cnt_reg <= rec_cnt_reg)
        else $error("match counter exceeds record counter");

endmodule

FILE: verif/substring_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_filter_checker
// Watches both channels of the record substring filter, tracks pattern,
// window and tallies for every accepted word, and compares each result word
// field by field with the oldest predicted record result.
// ----------------------------------------------------------------------------
module substring_filter_checker
    import rsf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [1:0]       action,
    input  logic [7:0]       data_byte,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic             record_matched,
    input  logic [CNT_W-1:0] record_index,
    input  logic [CNT_W-1:0] match_count,
    input  logic             first_match_res,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic             matched;
        logic [CNT_W-1:0] index;
        logic [CNT_W-1:0] count;
        logic             first;
    } record_verdict_t;

    rsf_byte_t        pattern_bytes [MAX_PATTERN];
    rsf_byte_t        window_bytes  [MAX_PATTERN];
    int               pattern_len;
    int               record_bytes;
    logic             found;
    logic [CNT_W-1:0] records_done;
    logic [CNT_W-1:0] records_hit;
    record_verdict_t  awaited_records [$];
    record_verdict_t  oldest;
    int               mismatch_total = 0;

    function automatic void restart_record();
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            window_bytes[k] = '0;
        end
        record_bytes = 0;
        found        = 1'b0;
    endfunction

    function automatic void absorb_word(rsf_action_t act, rsf_byte_t value);
        record_verdict_t verdict;
        logic            hit;
        case (act)
            ACT_LOAD:
            begin
                if (pattern_len < MAX_PATTERN)
                begin
                    pattern_bytes[pattern_len] = value;
                    pattern_len++;
                end
            end
            ACT_CLEAR:
            begin
                pattern_len  = 0;
                records_done = '0;
                records_hit  = '0;
                restart_record();
            end
            ACT_TEXT:
            begin
                for (int k = MAX_PATTERN - 1; k > 0; k--)
                begin
                    window_bytes[k] = window_bytes[k-1];
                end
                window_bytes[0] = value;
                if (record_bytes < MAX_PATTERN)
                begin
                    record_bytes++;
                end
                if (record_bytes >= pattern_len)
                begin
                    hit = 1'b1;
                    for (int k = 0; k < pattern_len; k++)
                    begin
                        if (window_bytes[pattern_len-1-k] != pattern_bytes[k])
                        begin
                            hit = 1'b0;
                        end
                    end
                    if (hit)
                    begin
                        found = 1'b1;
                    end
                end
            end
            ACT_END:
            begin
                verdict.matched = found || (pattern_len == 0);
                verdict.first   = verdict.matched && (records_hit == '0);
                verdict.index   = records_done;
                if (verdict.matched && records_hit != CNT_MAX)
                begin
                    records_hit++;
                end
                if (records_done != CNT_MAX)
                begin
                    records_done++;
                end
                verdict.count = records_hit;
                awaited_records.push_back(verdict);
                restart_record();
            end
        endcase
    endfunction

    function automatic void compare_field(string field, int want, int seen);
        if (want != seen)
        begin
            mismatch_total++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, seen);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len  = 0;
            records_done = '0;
            records_hit  = '0;
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                pattern_bytes[k] = '0;
            end
            restart_record();
            awaited_records.delete();
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                absorb_word(rsf_action_t'(action), data_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_records.size() == 0)
                begin
                    mismatch_total++;
                    $display("%0t: result word mismatch, expected none, actual %0d/%0d/%0d/%0d",
                             $time, record_matched, record_index, match_count,
                             first_match_res);
                end
                else
                begin
                    oldest = awaited_records.pop_front();
                    compare_field("record_matched", int'(oldest.matched),
                                  int'(record_matched));
                    compare_field("record_index", int'(oldest.index),
                                  int'(record_index));
                    compare_field("match_count", int'(oldest.count),
                                  int'(match_count));
                    compare_field("first_match_res", int'(oldest.first),
                                  int'(first_match_res));
                end
            end
            fail_count    <= mismatch_total;
            pending_count <= awaited_records.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the record substring filter: a directed pass over
// empty, short, full and mid-record cases, random patterns and records with
// random idling on both channels, then a closing stretch with no idling.
// ----------------------------------------------------------------------------
module tb_top;
    import rsf_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_WORDS = 1800;
    localparam int TAIL_RECORDS = 20;
    localparam int DRAIN_CYCLES = 12;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic [1:0]       action    = ACT_LOAD;
    logic [7:0]       data_byte = 8'h00;
    logic             out_stall = 1'b0;
    logic             in_stall;
    logic             out_valid;
    logic             record_matched;
    logic [CNT_W-1:0] record_index;
    logic [CNT_W-1:0] match_count;
    logic             first_match_res;
    int               fail_count;
    int               pending_count;

    logic      idle_enable = 1'b1;
    int        stall_left  = 0;
    int        quiet_cycles = 0;
    int        words_sent  = 0;
    int        random_goal;
    int        pick;
    rsf_byte_t pattern_copy [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    record_substring_filter dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .record_matched  (record_matched),
        .record_index    (record_index),
        .match_count     (match_count),
        .first_match_res (first_match_res)
    );

    substring_filter_checker filter_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .record_matched  (record_matched),
        .record_index    (record_index),
        .match_count     (match_count),
        .first_match_res (first_match_res),
        .fail_count      (fail_count),
        .pending_count   (pending_count)
    );

    always @(negedge clk)
    begin
        if (!idle_enable)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_word(input rsf_action_t act, input rsf_byte_t value);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 5);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (act == ACT_LOAD && pattern_copy.size() < MAX_PATTERN)
        begin
            pattern_copy.push_back(value);
        end
        else if (act == ACT_CLEAR)
        begin
            pattern_copy.delete();
        end
    endtask

    function automatic rsf_byte_t pick_byte();
        if ($urandom_range(0, 4) == 0)
        begin
            return rsf_byte_t'($urandom_range(0, 255));
        end
        return rsf_byte_t'(8'h61 + $urandom_range(0, 2));
    endfunction

    task automatic load_pattern();
        int n;
        if ($urandom_range(0, 3) != 0)
        begin
            send_word(ACT_CLEAR, rsf_byte_t'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            n = $urandom_range(0, 4);
        end
        else if (pick < 95)
        begin
            n = $urandom_range(5, 10);
        end
        else
        begin
            n = $urandom_range(30, 34);
        end
        repeat (n)
        begin
            send_word(ACT_LOAD, pick_byte());
        end
    endtask

    task automatic send_record();
        int        len;
        int        spot;
        rsf_byte_t body [$];
        if ($urandom_range(0, 19) == 0)
        begin
            len = $urandom_range(20, 45);
        end
        else
        begin
            len = $urandom_range(0, 12);
        end
        for (int k = 0; k < len; k++)
        begin
            body.push_back(pick_byte());
        end
        // plant the pattern in half the records that can hold it
        if (pattern_copy.size() > 0 && pattern_copy.size() <= len && $urandom_range(0, 1))
        begin
            spot = $urandom_range(0, len - pattern_copy.size());
            for (int k = 0; k < pattern_copy.size(); k++)
            begin
                body[spot+k] = pattern_copy[k];
            end
        end
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 49) == 0)
            begin
                send_word($urandom_range(0, 3) == 0 ? ACT_CLEAR : ACT_LOAD, pick_byte());
            end
            send_word(ACT_TEXT, body[k]);
        end
        send_word(ACT_END, rsf_byte_t'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_word(ACT_END, 8'hFF);
        send_word(ACT_TEXT, 8'h00);
        send_word(ACT_TEXT, 8'hFF);
        send_word(ACT_END, 8'h00);
        send_word(ACT_LOAD, 8'hFF);
        send_word(ACT_LOAD, 8'h00);
        send_word(ACT_TEXT, 8'hFF);
        send_word(ACT_END, 8'h00);
        send_word(ACT_TEXT, 8'h00);
        send_word(ACT_END, 8'h00);
        send_word(ACT_TEXT, 8'hFF);
        send_word(ACT_TEXT, 8'h00);
        send_word(ACT_END, 8'h00);
        // lengthen the pattern after a hit inside the record
        send_word(ACT_TEXT, 8'hFF);
        send_word(ACT_TEXT, 8'h00);
        send_word(ACT_LOAD, 8'h55);
        send_word(ACT_END, 8'h00);
        // drop the open record with a clear
        send_word(ACT_TEXT, 8'h55);
        send_word(ACT_CLEAR, 8'hAA);
        send_word(ACT_END, 8'h00);

        // fill the pattern, one load past full, then a full-width hit
        send_word(ACT_CLEAR, 8'h00);
        repeat (MAX_PATTERN + 1)
        begin
            send_word(ACT_LOAD, rsf_byte_t'($urandom_range(0, 255)));
        end
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            send_word(ACT_TEXT, pattern_copy[k]);
        end
        send_word(ACT_END, 8'h00);

        send_word(ACT_CLEAR, 8'h00);
        send_word(ACT_LOAD, 8'h61);
        send_word(ACT_LOAD, 8'h62);
        random_goal = words_sent + RANDOM_WORDS;
        while (words_sent < random_goal)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                idle_enable = !idle_enable;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                load_pattern();
            end
            else if (pick < 12)
            begin
                send_word(rsf_action_t'($urandom_range(0, 3)),
                          rsf_byte_t'($urandom_range(0, 255)));
            end
            else
            begin
                send_record();
            end
        end

        // finish with records and no idling on either side
        idle_enable = 1'b0;
        repeat (TAIL_RECORDS)
        begin
            send_record();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
